[src/rtc_pkg.sv]
// rtc_pkg: shared types, constants and helpers for the route transposition cipher
// used by rtc_ctrl and route_transposition_cipher; no dependencies
package rtc_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam int DIM_W      = 4;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CHAR_W-1:0] PAD_BYTE   = 8'h78;
  localparam logic [DIM_W-1:0]  GRID_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } rtc_state_t;

  // travels alongside the registered ram read
  typedef struct packed {
    logic valid;
    logic pad;
    logic last;
  } emit_tag_t;

  // zero counts as one, anything above the maximum is the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > int'(hi)) begin
      r = DIM_W'(hi);
    end
    return r;
  endfunction

endpackage

[src/rtc_ram.sv]
// rtc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/rtc_ctrl.sv]
// rtc_ctrl: load counter and serpentine route sequencer driving the cell ram
// depends on rtc_pkg
module rtc_ctrl #(
  parameter int MAX_ROWS = rtc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rtc_pkg::MAX_COLS_DEF,
  localparam int DEPTH  = MAX_ROWS * MAX_COLS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rtc_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_last,
  input  logic [rtc_pkg::DIM_W-1:0]     rows,
  input  logic [rtc_pkg::DIM_W-1:0]     cols,
  input  logic                          decrypt,
  output logic                          busy,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [rtc_pkg::CHAR_W-1:0]    mem_wdata,
  output logic [ADDR_W-1:0]             mem_raddr,
  output rtc_pkg::emit_tag_t            tag
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > rtc_pkg::PROD_W) ? CNT_W : rtc_pkg::PROD_W;

  rtc_pkg::rtc_state_t state, state_next;

  logic [CNT_W-1:0]            bytes_loaded;
  logic [rtc_pkg::DIM_W-1:0]   outer;
  logic [rtc_pkg::DIM_W-1:0]   inner;

  logic                        accept;
  logic                        emitting;
  logic                        emit_end;
  logic                        can_store;
  logic [rtc_pkg::PROD_W-1:0]  grid_size;
  logic [rtc_pkg::DIM_W-1:0]   inner_lim;
  logic [rtc_pkg::DIM_W-1:0]   outer_lim;
  logic [rtc_pkg::DIM_W-1:0]   row_i;
  logic [rtc_pkg::DIM_W-1:0]   col_j;
  logic [rtc_pkg::DIM_W-1:0]   row_sel;
  logic [rtc_pkg::DIM_W-1:0]   mul_a;
  logic [rtc_pkg::DIM_W-1:0]   mul_b;
  logic [rtc_pkg::DIM_W-1:0]   add_c;
  logic [rtc_pkg::PROD_W-1:0]  pos;
  logic                        pad_now;

  assign accept    = start && (state == rtc_pkg::ST_IDLE);
  assign grid_size = rtc_pkg::PROD_W'(rows) * rtc_pkg::PROD_W'(cols);
  assign can_store = CMP_W'(bytes_loaded) < CMP_W'(grid_size);

  // encrypt walks columns outside, decrypt walks rows outside
  assign outer_lim = decrypt ? rows : cols;
  assign inner_lim = decrypt ? cols : rows;
  assign row_i     = decrypt ? outer : inner;
  assign col_j     = decrypt ? inner : outer;
  assign row_sel   = col_j[0] ? (rows - rtc_pkg::DIM_W'(1) - row_i) : row_i;

  // encrypt: row_sel * cols + col_j, decrypt: col_j * rows + row_sel
  assign mul_a = decrypt ? col_j : row_sel;
  assign mul_b = decrypt ? rows : cols;
  assign add_c = decrypt ? row_sel : col_j;
  assign pos   = rtc_pkg::PROD_W'(mul_a) * rtc_pkg::PROD_W'(mul_b)
               + rtc_pkg::PROD_W'(add_c);

  assign pad_now  = CMP_W'(pos) >= CMP_W'(bytes_loaded);
  assign emit_end = (inner == inner_lim - rtc_pkg::DIM_W'(1))
                 && (outer == outer_lim - rtc_pkg::DIM_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      rtc_pkg::ST_IDLE: begin
        if (accept && in_last) begin
          state_next = rtc_pkg::ST_EMIT;
        end
      end
      rtc_pkg::ST_EMIT: begin
        if (emit_end) begin
          state_next = rtc_pkg::ST_IDLE;
        end
      end
      default: state_next = rtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    emitting = 1'b0;
    mem_we   = 1'b0;
    case (state)
      rtc_pkg::ST_IDLE: begin
        mem_we = accept && can_store;
      end
      rtc_pkg::ST_EMIT: begin
        busy     = 1'b1;
        emitting = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign mem_waddr = bytes_loaded[ADDR_W-1:0];
  assign mem_wdata = in_char;
  assign mem_raddr = ADDR_W'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rtc_pkg::ST_IDLE;
      bytes_loaded <= '0;
      outer        <= '0;
      inner        <= '0;
      tag          <= '0;
    end else begin
      state     <= state_next;
      tag.valid <= emitting;
      tag.pad   <= pad_now;
      tag.last  <= emitting && emit_end;
      if (mem_we) begin
        bytes_loaded <= bytes_loaded + CNT_W'(1);
      end
      if (emitting) begin
        if (emit_end) begin
          bytes_loaded <= '0;
          outer        <= '0;
          inner        <= '0;
        end else if (inner == inner_lim - rtc_pkg::DIM_W'(1)) begin
          inner <= '0;
          outer <= outer + rtc_pkg::DIM_W'(1);
        end else begin
          inner <= inner + rtc_pkg::DIM_W'(1);
        end
      end
    end
  end

endmodule

[src/route_transposition_cipher.sv]
// route_transposition_cipher: top level, config registers, cell ram and output stage
// depends on rtc_pkg, rtc_ram and rtc_ctrl
//
// Usage:
//   Message bytes arrive on in_char/in_last; a transaction is taken at a rising
//   edge with start high and busy low, one byte per cycle while loading. Bytes
//   beyond the clamped grid (rows times columns) are dropped. The byte with
//   in_last set is stored (if there is room) and starts emission: busy rises on
//   the next cycle and stays high while each cell of the clamped grid is read,
//   one ram read per cycle. Results appear on out_char/out_last in the cycle
//   after each read, marked by out_valid for one cycle each; the first result
//   follows the last byte through the state register and then the ram read register.
//   The receiver cannot stall, so the stream never pauses. Cells that no
//   byte reached read as 'x'. Throughput: one byte per cycle when loading,
//   one result per cycle when emitting, set by the single ram read port.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 rows, 1 cols,
//   2 decrypt_mode) and cfg_data; cfg_ready is low during emission and writes
//   are meant for idle time only. Dimensions of 0 act as 1, above the maximum
//   as the maximum. Reset (rst, synchronous) sets an 8 by 8 grid, encrypt mode,
//   and an empty message; ram contents are not cleared.
module route_transposition_cipher #(
  parameter int MAX_ROWS = rtc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rtc_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rtc_pkg::CHAR_W-1:0]        in_char,
  input  logic                              in_last,
  output logic                              out_valid,
  output logic [rtc_pkg::CHAR_W-1:0]        out_char,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [rtc_pkg::DIM_W-1:0]  grid_rows;
  logic [rtc_pkg::DIM_W-1:0]  grid_cols;
  logic                       decrypt_mode;
  logic [rtc_pkg::DIM_W-1:0]  rows_eff;
  logic [rtc_pkg::DIM_W-1:0]  cols_eff;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [rtc_pkg::CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [rtc_pkg::CHAR_W-1:0] mem_rdata;
  rtc_pkg::emit_tag_t         tag;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= rtc_pkg::GRID_RESET;
      grid_cols    <= rtc_pkg::GRID_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtc_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data[rtc_pkg::DIM_W-1:0];
        rtc_pkg::REG_GRID_COLS:    grid_cols    <= cfg_data[rtc_pkg::DIM_W-1:0];
        rtc_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign rows_eff = rtc_pkg::clamp_dim(grid_rows, MAX_ROWS);
  assign cols_eff = rtc_pkg::clamp_dim(grid_cols, MAX_COLS);

  rtc_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_char   (in_char),
    .in_last   (in_last),
    .rows      (rows_eff),
    .cols      (cols_eff),
    .decrypt   (decrypt_mode),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .tag       (tag)
  );

  rtc_ram #(
    .WIDTH (rtc_pkg::CHAR_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid = tag.valid;
  assign out_last  = tag.last;
  assign out_char  = tag.pad ? rtc_pkg::PAD_BYTE : mem_rdata;

endmodule

[src/rtc_checker.sv]
// rtc_checker: port-level assertions for route_transposition_cipher, bound to the top
// depends on route_transposition_cipher
module rtc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic in_last,
  input logic out_valid,
  input logic out_last
);

  // a final byte always opens an emission
  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_last |=> busy)
    else $error("final byte did not start emission");

  // every result is preceded by a busy cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(busy))
    else $error("result without a preceding read cycle");

  a_last_is_valid: assert property (@(posedge clk) disable iff (rst)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // emission ends cleanly, nothing trails the final result
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    out_last |=> !out_valid)
    else $error("result right after the final one");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind route_transposition_cipher rtc_checker u_rtc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_last  (out_last)
);
